/* src/binary_tile_change_gate_macros.svh */
// Assertion macros shared by the tile change gate RTL.
`ifndef BINARY_TILE_CHANGE_GATE_MACROS_SVH
`define BINARY_TILE_CHANGE_GATE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BTCG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BTCG_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* src/btcg_pkg.sv */
// Package: shared constants and types of the tile change gate.
`timescale 1ns / 1ps
`default_nettype none
package btcg_pkg;

	localparam int ROW_BITS   = 8;
	localparam int WIDTH_W    = 4;
	localparam int THR_W      = 9;
	localparam int Q_BITS     = 8;
	localparam int PADDR_W    = 1;
	localparam int PDATA_W    = 32;
	localparam int THR_RESET  = 128;
	localparam int DEF_TILE_W = 8;
	localparam int DEF_TILE_H = 8;

	// register addresses
	localparam logic [PADDR_W-1:0] REG_THRESHOLD = '0;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	// what one pixel lane found
	typedef struct packed {
		logic cur;
		logic prev;
		logic same;
	} lane_flags_t;

endpackage
`default_nettype wire

/* src/btcg_lane.sv */
// One pixel lane: masks the pixel pair and flags a match.
`timescale 1ns / 1ps
`default_nettype none
module btcg_lane (
	input  wire logic               cur_bit,
	input  wire logic               prev_bit,
	input  wire logic               lane_on,
	output btcg_pkg::lane_flags_t   flags
);

	// mask both bits, flag identical valid pixels
	always_comb begin
		flags.cur  = cur_bit & lane_on;
		flags.prev = prev_bit & lane_on;
		flags.same = lane_on & ~(cur_bit ^ prev_bit);
	end

endmodule
`default_nettype wire

/* src/btcg_merge.sv */
// Merge stage: gathers lane bits into rows and counts matches and ones.
`timescale 1ns / 1ps
`default_nettype none
module btcg_merge #(
	parameter int LANES = btcg_pkg::DEF_TILE_W
) (
	input  wire btcg_pkg::lane_flags_t               flags [LANES],
	output logic [btcg_pkg::ROW_BITS-1:0]            cur_bits,
	output logic [btcg_pkg::ROW_BITS-1:0]            prev_bits,
	output logic [$clog2(LANES+1)-1:0]               same_cnt,
	output logic [$clog2(LANES+1)-1:0]               ones_cnt
);

	localparam int LCNT_W = $clog2(LANES + 1);

	// rebuild the masked rows, pixels past the lanes stay zero
	always_comb begin
		cur_bits  = '0;
		prev_bits = '0;
		for (int k = 0; k < LANES; k++) begin
			cur_bits[k]  = flags[k].cur;
			prev_bits[k] = flags[k].prev;
		end
	end

	// add up the lane flags
	always_comb begin
		same_cnt = '0;
		ones_cnt = '0;
		for (int k = 0; k < LANES; k++) begin
			same_cnt = same_cnt + LCNT_W'(flags[k].same);
			ones_cnt = ones_cnt + LCNT_W'(flags[k].cur);
		end
	end

endmodule
`default_nettype wire

/* src/binary_tile_change_gate.sv */
// Top level: tile change gate with row store, decision and row emitter.
//
// Usage: feed tile rows on cur_row/prev_row/row_width/last_row with start;
// a word is taken at a clock edge where start is high and busy is low.
// Each row passes through one pixel lane per column in the same cycle, and
// the row counts are added to the tile totals. Rows are held in a small
// register store of MAX_TILE_H entries.
// A row with last_row set, or the row that fills MAX_TILE_H, ends the tile.
// In the cycle after that the gate compares same*256 against threshold*pixels (one
// 9-bit multiply) and then emits every stored row, one per cycle, on
// out_row/out_last, each marked by out_valid for exactly one cycle. The
// receiver cannot stall; rows are lost if not taken.
// Busy stays high from the end of a tile through the decide and emit states;
// each output word is registered from the emit state.
// threshold_q8 sits at byte address 0 of the APB port (reset 128); write it
// only while idle. Reset clears the counters and the sequencer; the row
// store holds no reset value and is only read where written in the tile.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_tile_change_gate_macros.svh"
module binary_tile_change_gate #(
	parameter int MAX_TILE_W = btcg_pkg::DEF_TILE_W,
	parameter int MAX_TILE_H = btcg_pkg::DEF_TILE_H
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [btcg_pkg::ROW_BITS-1:0]    cur_row,
	input  wire logic [btcg_pkg::ROW_BITS-1:0]    prev_row,
	input  wire logic [btcg_pkg::WIDTH_W-1:0]     row_width,
	input  wire logic                             last_row,
	// result channel
	output logic                                  out_valid,
	output logic [btcg_pkg::ROW_BITS-1:0]         out_row,
	output logic                                  out_last,
	// configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [btcg_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [btcg_pkg::PDATA_W-1:0]     pwdata,
	output logic [btcg_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);

	localparam int LANES  = (MAX_TILE_W < btcg_pkg::ROW_BITS) ? MAX_TILE_W
	                                                          : btcg_pkg::ROW_BITS;
	localparam int LCNT_W = $clog2(LANES + 1);
	localparam int CNT_W  = $clog2(LANES * MAX_TILE_H + 1);
	localparam int ROWS_W = $clog2(MAX_TILE_H + 1);
	localparam int IDX_W  = (MAX_TILE_H > 1) ? $clog2(MAX_TILE_H) : 1;
	localparam int PROD_W = btcg_pkg::THR_W + CNT_W;
	localparam int WW     = btcg_pkg::WIDTH_W;

	btcg_pkg::state_t                 state_q, state_d;
	logic [btcg_pkg::THR_W-1:0]       threshold_q;
	logic [ROWS_W-1:0]                rows_held_q;
	logic [CNT_W-1:0]                 same_cnt_q, ones_cnt_q, pixel_cnt_q;
	logic [IDX_W-1:0]                 emit_idx_q;
	logic                             take_q;
	logic                             out_valid_q, out_last_q;
	logic [btcg_pkg::ROW_BITS-1:0]    out_row_q;
	logic [btcg_pkg::ROW_BITS-1:0]    cur_rows_q  [MAX_TILE_H];
	logic [btcg_pkg::ROW_BITS-1:0]    prev_rows_q [MAX_TILE_H];

	logic                             accept, tile_end, emit_last;
	logic                             decide_en, emit_en;
	logic [WW-1:0]                    w_eff;
	btcg_pkg::lane_flags_t            flags [LANES];
	logic [btcg_pkg::ROW_BITS-1:0]    cur_bits, prev_bits;
	logic [LCNT_W-1:0]                row_same, row_ones;
	logic [PROD_W-1:0]                same_scaled, thr_scaled;
	logic                             take_cur;
	logic                             cfg_write;

	// clamp the row width to the lane count
	assign w_eff = (row_width > WW'(LANES)) ? WW'(LANES) : row_width;

	// one lane per pixel column
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		btcg_lane u_lane (
			.cur_bit  (cur_row[k]),
			.prev_bit (prev_row[k]),
			.lane_on  (WW'(k) < w_eff),
			.flags    (flags[k])
		);
	end

	btcg_merge #(
		.LANES (LANES)
	) u_merge (
		.flags     (flags),
		.cur_bits  (cur_bits),
		.prev_bits (prev_bits),
		.same_cnt  (row_same),
		.ones_cnt  (row_ones)
	);

	assign accept    = start && !busy;
	assign tile_end  = last_row || (rows_held_q == ROWS_W'(MAX_TILE_H - 1));
	assign emit_last = (ROWS_W'(emit_idx_q) + ROWS_W'(1)) == rows_held_q;

	// compare same*256 against threshold*pixels, or pick a flat tile
	assign same_scaled = PROD_W'({same_cnt_q, {btcg_pkg::Q_BITS{1'b0}}});
	assign thr_scaled  = PROD_W'(threshold_q) * PROD_W'(pixel_cnt_q);
	assign take_cur    = (same_scaled < thr_scaled) || (ones_cnt_q == '0)
	                     || (ones_cnt_q == pixel_cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btcg_pkg::ST_IDLE: begin
				if (accept && tile_end) state_d = btcg_pkg::ST_DECIDE;
			end
			btcg_pkg::ST_DECIDE: begin
				state_d = btcg_pkg::ST_EMIT;
			end
			btcg_pkg::ST_EMIT: begin
				if (emit_last) state_d = btcg_pkg::ST_IDLE;
			end
			default: state_d = btcg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy      = 1'b1;
		decide_en = 1'b0;
		emit_en   = 1'b0;
		unique case (state_q)
			btcg_pkg::ST_IDLE:   busy = 1'b0;
			btcg_pkg::ST_DECIDE: decide_en = 1'b1;
			btcg_pkg::ST_EMIT:   emit_en = 1'b1;
			default:             busy = 1'b1;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btcg_pkg::ST_IDLE;
			rows_held_q <= '0;
			same_cnt_q  <= '0;
			ones_cnt_q  <= '0;
			pixel_cnt_q <= '0;
			emit_idx_q  <= '0;
			take_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= emit_en;
			if (accept) begin
				rows_held_q <= rows_held_q + ROWS_W'(1);
				same_cnt_q  <= same_cnt_q + CNT_W'(row_same);
				ones_cnt_q  <= ones_cnt_q + CNT_W'(row_ones);
				pixel_cnt_q <= pixel_cnt_q + CNT_W'(w_eff);
			end
			if (decide_en) begin
				take_q      <= take_cur;
				emit_idx_q  <= '0;
				same_cnt_q  <= '0;
				ones_cnt_q  <= '0;
				pixel_cnt_q <= '0;
			end
			if (emit_en) begin
				emit_idx_q <= emit_idx_q + IDX_W'(1);
				if (emit_last) rows_held_q <= '0;
			end
		end
	end

	// store the masked rows
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_rows_q[rows_held_q[IDX_W-1:0]]  <= cur_bits;
			prev_rows_q[rows_held_q[IDX_W-1:0]] <= prev_bits;
		end
	end

	// load the output word from the chosen tile
	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_row_q  <= take_q ? cur_rows_q[emit_idx_q] : prev_rows_q[emit_idx_q];
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_last  = out_last_q;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == btcg_pkg::REG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= btcg_pkg::THR_W'(btcg_pkg::THR_RESET);
		end else if (cfg_write) begin
			threshold_q <= pwdata[btcg_pkg::THR_W-1:0];
		end
	end

	assign prdata = (paddr == btcg_pkg::REG_THRESHOLD) ?
	                btcg_pkg::PDATA_W'(threshold_q) : '0;

	// checks
	`BTCG_ASSERT(a_tile_end_decides, (accept && tile_end) |=> (state_q == btcg_pkg::ST_DECIDE), "tile end did not start the decision")
	`BTCG_ASSERT(a_out_from_emit, out_valid_q |-> $past(state_q == btcg_pkg::ST_EMIT), "output word outside emission")
	`BTCG_ASSERT(a_last_ends_tile, (out_valid_q && out_last_q) |-> (state_q == btcg_pkg::ST_IDLE && rows_held_q == '0), "last word did not close the tile")
	`BTCG_NEVER(a_rows_bound, rows_held_q > ROWS_W'(MAX_TILE_H), "row count past tile height")

endmodule
`default_nettype wire
